>>> rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
        logic                     keep;
    } t_link;

endpackage

>>> rtl/spq_if.sv
interface spq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [spq_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface spq_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [spq_pkg::DATA_W-1:0]  removed_value;
    logic signed [spq_pkg::DATA_W-1:0]  front_value;
    logic signed [spq_pkg::DATA_W-1:0]  rear_value;
    logic [spq_pkg::COUNT_W-1:0]        count;
    logic                               empty_res;

    modport source (output valid, output status, output removed_value, output front_value,
                    output rear_value, output count, output empty_res, input ready);
    modport sink   (input valid, input status, input removed_value, input front_value,
                    input rear_value, input count, input empty_res, output ready);
endinterface

>>> rtl/spq_cell.sv
module spq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spq_pkg::t_cmd        i_cmd,
    input  spq_pkg::t_link       i_left,
    input  spq_pkg::t_link       i_right,
    output spq_pkg::t_link       o_link
);

    logic signed [spq_pkg::DATA_W-1:0] r_value, n_value;
    logic                              r_valid, n_valid;
    logic                              keep;

    // hold position when the stored value is ahead of (or equal to) the new one
    assign keep = r_valid && (r_value >= i_cmd.value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.ins && !keep) begin
            if (i_left.keep) begin
                n_value = i_cmd.value;
                n_valid = 1'b1;
            end else begin
                n_value = i_left.value;
                n_valid = i_left.valid;
            end
        end else if (i_cmd.rem) begin
            n_value = i_right.value;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.valid = r_valid;
    assign o_link.keep  = keep;

endmodule

>>> rtl/sorted_priority_queue.sv
// Bounded priority queue of signed 32-bit values, held sorted in a chain of
// spq_pkg::DEPTH cells with the largest value at the front. An insert (op 0)
// lands behind every equal or larger value, so equal values leave first-in,
// first-out; a remove (op 1) takes the front entry. Each request transfer gives
// exactly one response transfer with status (0 ok, 1 insert dropped on full,
// 2 remove on empty), the removed value (zero unless a remove succeeded), and
// the front, rear, count and empty flag after the operation (front and rear
// read zero when empty; count is reported modulo 32). All cells compare and
// shift in parallel in the cycle of the request transfer; the next cycle forms
// the response from the cells, and the response is valid once that result is
// registered. The next request is taken once no result is being formed and
// the response register is free or being drained, so the block never takes a
// new request while the last one is still being formed.
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_in_if.sink        i_req,
    spq_out_if.source     o_rsp
);

    localparam int N = spq_pkg::DEPTH;

    spq_pkg::t_cmd  cmd;
    spq_pkg::t_link link [N];
    spq_pkg::t_link left_of  [N];
    spq_pkg::t_link right_of [N];

    logic r_busy;
    logic r_out_valid;
    logic [1:0] r_status;
    logic signed [spq_pkg::DATA_W-1:0] r_removed;
    logic signed [spq_pkg::DATA_W-1:0] r_front;
    logic signed [spq_pkg::DATA_W-1:0] r_rear;
    logic [spq_pkg::COUNT_W-1:0] r_count_out;
    logic r_empty;
    logic [spq_pkg::CNT_W-1:0] r_count;

    logic accept;
    logic full;
    logic empty;
    logic signed [spq_pkg::DATA_W-1:0] rear;
    logic [spq_pkg::CNT_W+spq_pkg::COUNT_W-1:0] count_ext;

    // take a request only when no result is being formed and the response
    // register is free or transfers in this cycle
    assign i_req.ready = !r_busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign full  = link[N-1].valid;
    assign empty = !link[0].valid;

    // broadcast: drop an insert into a full queue, ignore a remove on empty
    assign cmd.ins   = accept && (i_req.op == spq_pkg::OP_INSERT) && !full;
    assign cmd.rem   = accept && (i_req.op == spq_pkg::OP_REMOVE) && !empty;
    assign cmd.value = i_req.value;

    // neighbor wiring; the front cell sees a left neighbor that always keeps,
    // the rear cell sees an empty right neighbor
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                left_of[i].value = '0;
                left_of[i].valid = 1'b1;
                left_of[i].keep  = 1'b1;
            end else begin
                left_of[i] = link[i-1];
            end
            if (i == N - 1) begin
                right_of[i].value = '0;
                right_of[i].valid = 1'b0;
                right_of[i].keep  = 1'b0;
            end else begin
                right_of[i] = link[i+1];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  (left_of[g]),
            .i_right (right_of[g]),
            .o_link  (link[g])
        );
    end

    // rear is the last valid cell: valid with an invalid right neighbor
    always_comb begin
        rear = '0;
        for (int i = 0; i < N; i++) begin
            if (link[i].valid && !right_of[i].valid) begin
                rear = rear | link[i].value;
            end
        end
    end

    assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, r_count};

    // control: busy for the cycle after a request transfer, then response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cmd.ins) begin
                r_count <= r_count + 1'b1;
            end else if (cmd.rem) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // payload: status and removed value at the transfer, the rest while r_busy is set
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_req.op == spq_pkg::OP_INSERT) begin
                r_status  <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                r_removed <= '0;
            end else begin
                r_status  <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
                r_removed <= empty ? '0 : link[0].value;
            end
        end
        if (r_busy) begin
            r_front     <= empty ? '0 : link[0].value;
            r_rear      <= rear;
            r_count_out <= count_ext[spq_pkg::COUNT_W-1:0];
            r_empty     <= empty;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.front_value   = r_front;
    assign o_rsp.rear_value    = r_rear;
    assign o_rsp.count         = r_count_out;
    assign o_rsp.empty_res     = r_empty;

endmodule

>>> sim/spq_outcome_checker.sv
module spq_outcome_checker
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_req,
    spq_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_full_drops,
    output int   o_empty_removes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] rear;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
    } outcome_t;

    // shadow of the sorted storage, front at index 0
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned              shadow_size = 0;
    outcome_t                 pending_outcomes [$];
    int                       fails = 0;
    int                       full_drops = 0;
    int                       empty_removes = 0;

    // apply one request to the shadow queue and return the response it must cause
    function automatic outcome_t apply_request(logic op, logic signed [DATA_W-1:0] value);
        outcome_t    res;
        int unsigned pos;
        res = '0;
        if (op == OP_INSERT) begin
            if (shadow_size >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // land behind every equal or larger value
                pos = 0;
                while (pos < shadow_size && shadow_entries[pos] >= value)
                    pos++;
                for (int unsigned i = shadow_size; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[pos] = value;
                shadow_size++;
            end
        end else begin
            if (shadow_size == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed = shadow_entries[0];
                for (int unsigned i = 1; i < shadow_size; i++)
                    shadow_entries[i - 1] = shadow_entries[i];
                shadow_size--;
            end
        end
        if (shadow_size > 0) begin
            res.front = shadow_entries[0];
            res.rear  = shadow_entries[shadow_size - 1];
        end
        res.count = shadow_size[COUNT_W-1:0];
        res.empty = (shadow_size == 0);
        return res;
    endfunction

    function automatic void check_field(string field, logic signed [DATA_W:0] want,
                                        logic signed [DATA_W:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        outcome_t want;
        outcome_t got;
        if (i_rst_n) begin
            // retire the response first: it can never belong to a request of this edge
            if (i_rsp.valid && i_rsp.ready) begin
                got.status  = i_rsp.status;
                got.removed = i_rsp.removed_value;
                got.front   = i_rsp.front_value;
                got.rear    = i_rsp.rear_value;
                got.count   = i_rsp.count;
                got.empty   = i_rsp.empty_res;
                if (pending_outcomes.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected response, expected none, got status %0d",
                             $time, got.status);
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("removed_value", want.removed, got.removed);
                    check_field("front_value", want.front, got.front);
                    check_field("rear_value", want.rear, got.rear);
                    check_field("count", want.count, got.count);
                    check_field("empty_res", want.empty, got.empty);
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = apply_request(i_req.op, i_req.value);
                if (want.status == ST_FULL)
                    full_drops++;
                if (want.status == ST_EMPTY)
                    empty_removes++;
                pending_outcomes.push_back(want);
            end
        end
        o_fail_count    <= fails;
        o_outstanding   <= pending_outcomes.size();
        o_full_drops    <= full_drops;
        o_empty_removes <= empty_removes;
    end

endmodule

>>> sim/sorted_priority_queue_tb.sv
// Stimulus and verdict for the sorted priority queue. A checker beside the
// block watches both channels, predicts every response and counts failures;
// this module only produces traffic and decides pass or fail at the end.
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int LONG_HOLD    = 80;   // receiver hold-off, in cycles
    localparam int SETTLE       = 10;   // cycles to wait after the last response
    localparam int HOLD_AGAIN   = 420;  // random item count that triggers a second hold-off
    localparam int DRAIN_AT     = 640;  // random item count that triggers a full drain

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;
    typedef enum {VAL_ANY, VAL_TIES, VAL_EDGE} value_kind_e;
    typedef enum {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int outstanding;
    int full_drops;
    int empty_removes;

    int inserts_sent  = 0;
    int removes_sent  = 0;
    int hold_requests = 0;  // raised by the sender side
    int hold_served   = 0;  // advanced by the receiver side
    int drains        = 0;

    spq_in_if  req_bus ();
    spq_out_if rsp_bus ();

    sorted_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    spq_outcome_checker outcome_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_bus),
        .i_rsp           (rsp_bus),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_full_drops    (full_drops),
        .o_empty_removes (empty_removes)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one item, starting at a rising edge. Look at ready in the middle of
    // the cycle, where nothing moves, and return at the edge of the transfer so
    // that the next item can follow with valid held high.
    task automatic offer(input logic op, input logic signed [DATA_W-1:0] value);
        req_bus.valid <= 1'b1;
        req_bus.op    <= op;
        req_bus.value <= value;
        do
            @(negedge i_clk);
        while (req_bus.ready !== 1'b1);
        @(posedge i_clk);
        if (op == OP_INSERT)
            inserts_sent++;
        else
            removes_sent++;
    endtask

    // Drop valid for a gap between bursts; a zero gap keeps the stream going.
    task automatic go_idle(input int cycles);
        if (cycles > 0) begin
            req_bus.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every expected response has come back. Look at the
    // count only after a rising edge, so the checker has counted the last transfer.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
        drains++;
    endtask

    // Mix full-range values with a narrow band that makes ties common and with
    // the signed extremes, so ordering, FIFO tie-breaking and every bit get hit.
    function automatic logic signed [DATA_W-1:0] pick_value();
        value_kind_e kind;
        logic signed [DATA_W-1:0] v;
        kind = value_kind_e'($urandom_range(0, 2));
        case (kind)
            VAL_ANY:  v = $urandom;
            VAL_TIES: v = $signed($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = 0;
                    3:       v = -1;
                    4:       v = VAL_MAX - 1;
                    default: v = VAL_MIN + 1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Bias the op so that the queue swings between full and empty.
    function automatic logic pick_op(mix_e mix);
        int pct;
        pct = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (pct < 20) ? OP_REMOVE : OP_INSERT;
            MIX_DRAIN: return (pct < 80) ? OP_REMOVE : OP_INSERT;
            default:   return (pct < 50) ? OP_REMOVE : OP_INSERT;
        endcase
    endfunction

    // Receiver: change stall pattern at random intervals, and serve a long
    // hold-off whenever the sender side asks for one.
    initial begin
        rx_mode_e mode;
        int       mode_left;
        int       tick;
        mode      = RX_STEADY;
        mode_left = 40;
        tick      = 0;
        forever begin
            if (hold_served < hold_requests) begin
                // hold ready low long enough for the block to back up its input
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_served++;
            end else begin
                case (mode)
                    RX_STEADY: rsp_bus.ready <= 1'b1;
                    RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
                    default:   rsp_bus.ready <= (tick % 4 == 0);
                endcase
                tick++;
                @(posedge i_clk);
                mode_left--;
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
            end
        end
    end

    // Sender: directed corners, then phases of biased random traffic.
    initial begin
        mix_e mix;
        int   phase_left;
        int   burst_left;
        int   sent;
        bit   gappy;

        req_bus.valid <= 1'b0;
        req_bus.op    <= OP_INSERT;
        req_bus.value <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // remove on an empty queue
        offer(OP_REMOVE, VAL_MAX);
        // extremes, zero and small values, with ties at both ends
        offer(OP_INSERT, VAL_MAX);
        offer(OP_INSERT, VAL_MIN);
        offer(OP_INSERT, 0);
        offer(OP_INSERT, -1);
        offer(OP_INSERT, 1);
        offer(OP_INSERT, 1);
        offer(OP_INSERT, VAL_MAX);
        offer(OP_INSERT, VAL_MIN);
        // fill to the last slot
        for (int i = 0; i < DEPTH - 8; i++)
            offer(OP_INSERT, (i % 3 == 0) ? 32'sd7 : $signed(i * 5 - 20));
        // insert into a full queue gets dropped
        offer(OP_INSERT, 32'sd12345);
        repeat (4) offer(OP_REMOVE, 0);
        wait_drained();

        // long receiver hold-off right as the random traffic starts
        hold_requests++;
        sent       = 0;
        burst_left = $urandom_range(1, 24);
        while (sent < RANDOM_ITEMS) begin
            mix        = mix_e'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 70);
            gappy      = ($urandom_range(0, 3) != 0);
            while (phase_left > 0 && sent < RANDOM_ITEMS) begin
                offer(pick_op(mix), pick_value());
                sent++;
                phase_left--;
                if (sent == HOLD_AGAIN)
                    hold_requests++;
                if (sent == DRAIN_AT) begin
                    wait_drained();
                    burst_left = $urandom_range(1, 24);
                end else begin
                    burst_left--;
                    if (burst_left == 0) begin
                        if (gappy)
                            go_idle($urandom_range(1, 5));
                        burst_left = $urandom_range(1, 40);
                    end
                end
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d inserts (%0d dropped while full) and %0d removes (%0d on empty).",
                 inserts_sent, full_drops, removes_sent, empty_removes);
        $display("Receiver held off %0d times for %0d cycles; sender waited for a drain %0d times.",
                 hold_served, LONG_HOLD, drains);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d responses still expected.", outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
sim/spq_outcome_checker.sv
sim/sorted_priority_queue_tb.sv
